>>> src/ggs_pkg.sv
package ggs_pkg;

  // number format of positions, angles and times
  localparam int FRAC_BITS = 10;
  localparam int POS_W     = 16;
  localparam int SPD_W     = 15;

  // offset and distance datapath
  localparam int OFS_W  = POS_W + 1;
  localparam int SQ_W   = 2 * OFS_W;
  localparam int ROOT_W = OFS_W;

  // cordic vectoring datapath
  localparam int ANG_FRAC     = 30;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;
  localparam int CORDIC_ITERS = 24;
  localparam int ITER_W       = 5;
  localparam int PRE_SHIFT    = 16;
  localparam int CX_W         = 36;
  localparam int CZ_W         = 34;
  localparam int BEAR_W       = CZ_W - ANG_SHIFT;
  localparam int DIFF_W       = 20;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // speed division
  localparam int NUM_W = ROOT_W + FRAC_BITS;
  localparam logic [SPD_W-1:0] SPEED_MAX = {SPD_W{1'b1}};

  // tolerances
  localparam int NEAR_TOL = 1 << (FRAC_BITS - 1);
  localparam int HEAD_TOL = ((1 << FRAC_BITS) + 50) / 100;

  // atan(2^-i) in q.30
  function automatic logic signed [CZ_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/ggs_isqrt.sv
module ggs_isqrt import ggs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [OFS_W-1:0] dx,
  input  logic signed [OFS_W-1:0] dy,
  output logic                    busy,
  output logic [ROOT_W-1:0]       root
);

  // two squaring steps, then one root bit per cycle
  localparam int STEPS = ROOT_W + 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int REM_W = ROOT_W + 4;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SQ_W-1:0]  acc_r, acc_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  logic signed [OFS_W-1:0]   mul_a;
  logic signed [2*OFS_W-1:0] prod;
  logic [REM_W-1:0] rem_sh, trial;
  logic             ge;

  assign mul_a  = (cnt_r == '0) ? dx : dy;
  assign prod   = mul_a * mul_a;
  assign rem_sh = {rem_r[REM_W-3:0], acc_r[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r < CNT_W'(2)) begin
        acc_nxt = acc_r + SQ_W'(prod);
      end else begin
        acc_nxt  = acc_r << 2;
        rem_nxt  = ge ? rem_sh - trial : rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], ge};
      end
      if (cnt_r == CNT_W'(STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

>>> src/ggs_cordic.sv
module ggs_cordic import ggs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [OFS_W-1:0]  dx,
  input  logic signed [OFS_W-1:0]  dy,
  output logic                     busy,
  output logic signed [BEAR_W-1:0] bearing
);

  logic                     busy_r, busy_nxt;
  logic                     zero_r, zero_nxt;
  logic [ITER_W-1:0]        i_r, i_nxt;
  logic signed [CX_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [CZ_W-1:0]   z_r, z_nxt;

  logic signed [CX_W-1:0]   xi, yi, x0, y0, xs, ys;
  logic signed [CZ_W-1:0]   z0, mag, rsum;
  logic [BEAR_W-1:0]        rmag;

  // pre-rotate into the right half plane
  always_comb begin
    xi = CX_W'(dx) <<< PRE_SHIFT;
    yi = CX_W'(dy) <<< PRE_SHIFT;
    x0 = xi;
    y0 = yi;
    z0 = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        x0 = yi;
        y0 = -xi;
        z0 = HALF_PI_Q30;
      end else begin
        x0 = -yi;
        y0 = xi;
        z0 = -HALF_PI_Q30;
      end
    end
  end

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_comb begin
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      zero_nxt = (dx == '0) && (dy == '0);
      i_nxt    = '0;
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = z0;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_q30(i_r);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_q30(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ITER_W'(CORDIC_ITERS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
    zero_r <= zero_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  // round half away from zero to the output lsb
  assign mag  = (z_r < 0) ? -z_r : z_r;
  assign rsum = mag + CZ_W'(1 << (ANG_SHIFT - 1));
  assign rmag = rsum[ANG_SHIFT +: BEAR_W];

  always_comb begin
    if (zero_r) bearing = '0;
    else if (z_r < 0) bearing = -signed'(rmag);
    else bearing = signed'(rmag);
  end

  assign busy = busy_r;

endmodule

>>> src/ggs_div.sv
module ggs_div import ggs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ROOT_W-1:0] num,
  input  logic [SPD_W-1:0]  den,
  output logic              busy,
  output logic [SPD_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [SPD_W:0]   rem_r, rem_nxt;

  logic [SPD_W:0] rem_sh;
  logic           ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r[SPD_W-1:0], num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = {num, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, den} : rem_sh;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = (|quo_r[NUM_W-1:SPD_W]) ? SPEED_MAX : quo_r[SPD_W-1:0];

endmodule

>>> src/go_to_goal_steering.sv
// go-to-goal steering controller. each input word is one pose (x, y, heading,
// signed q5.10); each result word carries a forward speed, a turn command and
// the arrived / finished flags. the offset to the goal is fed at once to a
// bit-serial square root (two squaring steps on one shared multiplier, then
// one root bit per cycle) and to a 24-step cordic vectoring unit that runs
// alongside it; the cordic sets the pace. the first pose after reset also
// runs the 27-step restoring divider that latches the speed (distance /
// travel_time). in_stall is high while an item is in work; a finished
// result sits in an output register, so the next pose can be taken while
// the result waits. the speed reported is the one latched before the
// current pose (zero for the very first), and zero when within 0.5 of the
// goal. once the heading is within 0.01 of the target near the goal,
// finished is reported and later poses are taken and dropped without a
// result until reset. configuration must be written over the apb port
// only while the block is idle; the block does not enforce this. target_x
// at 0x0, target_y at 0x4, target_heading at 0x8, travel_time at 0xc.
module go_to_goal_steering import ggs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // pose input
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_heading,
  // command output
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SPD_W-1:0]        out_linear_speed,
  output logic signed [POS_W-1:0] out_angular_cmd,
  output logic                    out_arrived,
  output logic                    out_finished,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    REG_TARGET_X  = 2'd0,
    REG_TARGET_Y  = 2'd1,
    REG_TARGET_HD = 2'd2,
    REG_TRAVEL_T  = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CALC  = 6'b000010,
    S_WAIT  = 6'b000100,
    S_DIV   = 6'b001000,
    S_DWAIT = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  localparam logic signed [DIFF_W-1:0] HEAD_P  = DIFF_W'(HEAD_TOL);
  localparam logic signed [DIFF_W-1:0] HEAD_N  = -HEAD_P;
  localparam logic signed [DIFF_W-1:0] ANG_MAX = DIFF_W'(32767);
  localparam logic signed [DIFF_W-1:0] ANG_MIN = -DIFF_W'(32768);

  // configuration registers
  logic signed [POS_W-1:0] tx_r, ty_r, th_r;
  logic [SPD_W-1:0]        tt_r;
  reg_idx_t                widx;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
      th_r <= '0;
      tt_r <= SPD_W'(1 << FRAC_BITS);
    end else if (cfg_wr) begin
      unique case (widx)
        REG_TARGET_X:  tx_r <= pwdata[POS_W-1:0];
        REG_TARGET_Y:  ty_r <= pwdata[POS_W-1:0];
        REG_TARGET_HD: th_r <= pwdata[POS_W-1:0];
        REG_TRAVEL_T:  tt_r <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_TARGET_X:  prdata = {{(32-POS_W){1'b0}}, tx_r};
      REG_TARGET_Y:  prdata = {{(32-POS_W){1'b0}}, ty_r};
      REG_TARGET_HD: prdata = {{(32-POS_W){1'b0}}, th_r};
      REG_TRAVEL_T:  prdata = {{(32-SPD_W){1'b0}}, tt_r};
      default:       prdata = '0;
    endcase
  end

  // sequencer and item state
  state_t                  state_r, state_nxt;
  logic                    done_r, done_nxt;
  logic                    spd_valid_r, spd_valid_nxt;
  logic [SPD_W-1:0]        spd_latch_r, spd_latch_nxt;
  logic [SPD_W-1:0]        spd_out_r, spd_out_nxt;
  logic signed [OFS_W-1:0] dx_r, dy_r;
  logic signed [POS_W-1:0] hd_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [SPD_W-1:0]        o_speed_r;
  logic signed [POS_W-1:0] o_ang_r;
  logic                    o_near_r, o_fin_r;

  logic                     in_take, out_load;
  logic                     sq_busy, cd_busy, dv_busy;
  logic [ROOT_W-1:0]        root_dist;
  logic signed [BEAR_W-1:0] bear;
  logic [SPD_W-1:0]         quot;

  ggs_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_CALC),
    .dx    (dx_r),
    .dy    (dy_r),
    .busy  (sq_busy),
    .root  (root_dist)
  );

  ggs_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_CALC),
    .dx      (dx_r),
    .dy      (dy_r),
    .busy    (cd_busy),
    .bearing (bear)
  );

  ggs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV),
    .num   (root_dist),
    .den   (tt_r),
    .busy  (dv_busy),
    .quot  (quot)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // result decision
  logic                     near, fin;
  logic signed [DIFF_W-1:0] dif, ang_raw, ang_sel;
  logic signed [POS_W-1:0]  ang_sat;

  assign near    = root_dist < ROOT_W'(NEAR_TOL);
  assign dif     = DIFF_W'(th_r) - DIFF_W'(hd_r);
  assign fin     = near && (dif < HEAD_P) && (dif > HEAD_N);
  assign ang_raw = DIFF_W'(bear) - DIFF_W'(hd_r);
  assign ang_sel = (near && !fin) ? dif : ang_raw;

  always_comb begin
    if (ang_sel > ANG_MAX) ang_sat = POS_W'(ANG_MAX);
    else if (ang_sel < ANG_MIN) ang_sat = POS_W'(ANG_MIN);
    else ang_sat = ang_sel[POS_W-1:0];
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    done_nxt      = done_r;
    spd_valid_nxt = spd_valid_r;
    spd_latch_nxt = spd_latch_r;
    spd_out_nxt   = spd_out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        // after finish, words are taken and dropped
        if (in_take && !done_r) state_nxt = S_CALC;
      end
      S_CALC: state_nxt = S_WAIT;
      S_WAIT: begin
        if (!sq_busy && !cd_busy) begin
          spd_out_nxt = spd_valid_r ? spd_latch_r : '0;
          state_nxt   = spd_valid_r ? S_OUT : S_DIV;
        end
      end
      S_DIV: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (!dv_busy) begin
          spd_latch_nxt = quot;
          spd_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          done_nxt      = fin;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      spd_valid_r <= 1'b0;
      spd_latch_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      spd_valid_r <= spd_valid_nxt;
      spd_latch_r <= spd_latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    spd_out_r <= spd_out_nxt;
    if (in_take) begin
      dx_r <= OFS_W'(tx_r) - OFS_W'(in_pos_x);
      dy_r <= OFS_W'(ty_r) - OFS_W'(in_pos_y);
      hd_r <= in_heading;
    end
    if (out_load) begin
      o_speed_r <= near ? '0 : spd_out_r;
      o_ang_r   <= ang_sat;
      o_near_r  <= near;
      o_fin_r   <= fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_linear_speed = o_speed_r;
  assign out_angular_cmd  = o_ang_r;
  assign out_arrived      = o_near_r;
  assign out_finished     = o_fin_r;

  // finish is sticky until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done flag dropped without reset");

  // the speed latch is taken once only
  a_spd_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    spd_valid_r |=> spd_valid_r && $stable(spd_latch_r))
    else $error("latched speed changed");

  // finished implies arrived
  a_fin_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_arrived)
    else $error("finished without arrived");

  // arrived words carry zero speed
  a_near_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_linear_speed == '0)
    else $error("nonzero speed at goal");

  // no word is produced once finished
  a_no_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !out_valid |=> !out_valid)
    else $error("word after finish");

endmodule

>>> sim/go_to_goal_steering_test.sv
`timescale 1ns / 1ps

module go_to_goal_steering_test;
  import ggs_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 80;   // longer than the slowest item (first pose)
  localparam int PHASES       = 6;
  localparam int PER_PHASE    = 115;

  // register byte addresses
  localparam logic [3:0] REG_TARGET_X    = 4'h0;
  localparam logic [3:0] REG_TARGET_Y    = 4'h4;
  localparam logic [3:0] REG_TARGET_HEAD = 4'h8;
  localparam logic [3:0] REG_TRAVEL_TIME = 4'hc;

  typedef struct packed {
    logic [SPD_W-1:0]        speed;
    logic signed [POS_W-1:0] turn;
    logic                    arrived;
    logic                    finished;
  } steer_cmd_t;

  typedef struct {
    int         px, py, hd;
    bit         typed;
    steer_cmd_t cmd;
  } pose_row_t;

  logic                    clk = 0;
  logic                    rst_n = 0;
  logic                    in_valid = 0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_heading = '0;
  logic                    out_valid;
  logic                    out_stall = 0;
  logic [SPD_W-1:0]        out_linear_speed;
  logic signed [POS_W-1:0] out_angular_cmd;
  logic                    out_arrived, out_finished;
  logic                    psel = 0, penable = 0, pwrite = 0;
  logic [3:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  go_to_goal_steering DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state: goal registers plus the speed latch and finish flag
  int  goal_x, goal_y, goal_head, trip_time;
  int  held_speed;
  bit  speed_held, steer_done;
  bit  quiet;           // no idling on either side while set
  int  errors;
  int  cycles;
  steer_cmd_t cmd_queue[$];

  longint atan_steps[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // cordic vectoring bearing, rounded half away from zero to the pose lsb
  function automatic longint goal_bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys, mag, r;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_steps[i];
      end else begin
        x -= ys; y += xs; z -= atan_steps[i];
      end
    end
    mag = z < 0 ? -z : z;
    r = (mag + (64'sd1 << 19)) >>> 20;
    return z < 0 ? -r : r;
  endfunction

  function automatic longint pose_dist(int px, int py);
    longint dx, dy;
    dx = goal_x - px;
    dy = goal_y - py;
    return root_floor(dx * dx + dy * dy);
  endfunction

  // command for one pose, without touching the latch
  function automatic steer_cmd_t steer_for(int px, int py, int hd);
    steer_cmd_t c;
    longint span, ang, dif;
    span = pose_dist(px, py);
    ang = goal_bearing(goal_x - px, goal_y - py) - hd;
    c.speed = SPD_W'(held_speed);
    c.arrived = 0;
    c.finished = 0;
    if (span < NEAR_TOL) begin
      c.arrived = 1;
      c.speed = 0;
      dif = goal_head - hd;
      if (dif < HEAD_TOL && dif > -HEAD_TOL) c.finished = 1;
      else ang = dif;
    end
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    c.turn = POS_W'(ang);
    return c;
  endfunction

  // pose taken by the block: update the latch and queue the command
  task automatic take_pose(int px, int py, int hd, bit typed, steer_cmd_t typed_cmd);
    steer_cmd_t c;
    longint q;
    if (steer_done) return;
    c = steer_for(px, py, hd);
    if (!speed_held) begin
      if (trip_time == 0) q = 32767;
      else q = (pose_dist(px, py) << FRAC_BITS) / trip_time;
      held_speed = int'(q > 32767 ? 32767 : q);
      speed_held = 1;
    end
    if (c.finished) steer_done = 1;
    cmd_queue.push_back(typed ? typed_cmd : c);
  endtask

  task automatic send_pose(int px, int py, int hd, bit typed = 0, steer_cmd_t tc = '0);
    int gap;
    in_valid <= 1;
    in_pos_x <= POS_W'(px);
    in_pos_y <= POS_W'(py);
    in_heading <= POS_W'(hd);
    do @(posedge clk); while (in_stall);
    take_pose(px, py, hd, typed, tc);
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // wait out every command in flight, then let the block settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_goal(int tx, int ty, int th, int tt);
    reg_write(REG_TARGET_X, tx & 16'hffff);
    reg_write(REG_TARGET_Y, ty & 16'hffff);
    reg_write(REG_TARGET_HEAD, th & 16'hffff);
    reg_write(REG_TRAVEL_TIME, tt & 15'h7fff);
    goal_x = tx;
    goal_y = ty;
    goal_head = th;
    trip_time = tt;
  endtask

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int rand16();
    return $signed(16'($urandom));
  endfunction

  // random pose: mostly around the goal, never one that would finish
  task automatic random_pose();
    int px, py, hd, r;
    steer_cmd_t c;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      px = clamp16(goal_x + $urandom_range(0, 1200) - 600);
      py = clamp16(goal_y + $urandom_range(0, 1200) - 600);
    end else if (r < 6) begin
      px = clamp16(goal_x + $urandom_range(0, 4000) - 2000);
      py = clamp16(goal_y + $urandom_range(0, 4000) - 2000);
    end else begin
      px = rand16();
      py = rand16();
    end
    if ($urandom_range(0, 1)) hd = clamp16(goal_head + $urandom_range(0, 80) - 40);
    else hd = rand16();
    c = steer_for(px, py, hd);
    // near goal and on heading would silence the block for good
    if (c.finished) hd = goal_head + (goal_head < 0 ? 200 : -200);
    send_pose(px, py, hd);
  endtask

  // result side: stall drawn per word, compared with the oldest command
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_queue.size() == 0) begin
        $error("unexpected word: speed %0d turn %0d", out_linear_speed, out_angular_cmd);
        errors++;
      end else begin
        steer_cmd_t e;
        e = cmd_queue.pop_front();
        if (out_linear_speed !== e.speed) begin
          $error("linear_speed expected %0d got %0d", e.speed, out_linear_speed);
          errors++;
        end
        if (out_angular_cmd !== e.turn) begin
          $error("angular_cmd expected %0d got %0d", e.turn, out_angular_cmd);
          errors++;
        end
        if (out_arrived !== e.arrived) begin
          $error("arrived expected %0d got %0d", e.arrived, out_arrived);
          errors++;
        end
        if (out_finished !== e.finished) begin
          $error("finished expected %0d got %0d", e.finished, out_finished);
          errors++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 10);
      out_stall <= stall_left != 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= stall_left != 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("go_to_goal_steering_test NOT OK");
      $finish;
    end
  end

  pose_row_t rows[$];

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 0;
    goal_x = 0; goal_y = 0; goal_head = 0; trip_time = 1024;
    held_speed = 0; speed_held = 0; steer_done = 0;

    // typed rows assume goal at origin, heading 0, slowest travel time
    rows.push_back('{-32768, -32768, -32768, 1, '{0, 32767, 0, 0}});  // far corner, turn saturates
    rows.push_back('{32767, 32767, 32767, 1, '{1448, -32768, 0, 0}}); // latch shows now
    rows.push_back('{0, 0, 1000, 1, '{0, -1000, 1, 0}});              // on goal, off heading
    rows.push_back('{0, 0, -10, 1, '{0, 10, 1, 0}});                  // heading just out of tolerance
    rows.push_back('{0, 0, 10, 1, '{0, -10, 1, 0}});
    rows.push_back('{511, 0, 500, 1, '{0, -500, 1, 0}});              // just inside 0.5
    rows.push_back('{512, 0, 0, 0, '0});                              // just outside 0.5
    rows.push_back('{0, -32768, 0, 0, '0});
    rows.push_back('{-32768, 0, 32767, 0, '0});
    rows.push_back('{32767, -32768, -32768, 0, '0});
    rows.push_back('{0, 0, -32768, 1, '{0, 32767, 1, 0}});            // heading error saturates
    rows.push_back('{0, 0, 32767, 1, '{0, -32767, 1, 0}});
    rows.push_back('{-1, -1, 21845, 0, '0});
    rows.push_back('{300, -300, -21846, 0, '0});
    rows.push_back('{-600, 0, 3, 0, '0});
    rows.push_back('{0, 700, -3, 0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part, slowest travel time for the one speed latch of the run
    set_goal(0, 0, 0, 32767);
    foreach (rows[i]) send_pose(rows[i].px, rows[i].py, rows[i].hd, rows[i].typed, rows[i].cmd);
    drain();

    // random part over several goal settings, extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_goal(-32768, 32767, 32767, 1);
        1: set_goal(32767, -32768, -32768, 32767);
        default: set_goal(rand16(), rand16(), rand16(), $urandom_range(1, 32767));
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        random_pose();
      end
      quiet = 0;
      drain();
    end

    // finish on the goal, then poses that must stay silent
    set_goal($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
             $urandom_range(0, 2000) - 1000, $urandom_range(1, 32767));
    send_pose(goal_x + 100, goal_y - 100, goal_head + 5);
    repeat (4) send_pose(goal_x, goal_y, goal_head);
    drain();

    if (errors == 0) begin
      $display("go_to_goal_steering_test OK");
    end else begin
      $display("go_to_goal_steering_test NOT OK");
    end
    $finish;
  end

endmodule
